// ===== design/lca_nearest_alive_ancestor_defines.svh =====
// assertion helpers for the nearest alive ancestor block
`ifndef LCA_NEAREST_ALIVE_ANCESTOR_DEFINES_SVH
`define LCA_NEAREST_ALIVE_ANCESTOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define LCA_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lca check failed");
`define LCA_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lca check failed");
`else
`define LCA_ASSERT_IMP(name, ante, cons)
`define LCA_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== design/lca_pkg.sv =====
package lca_pkg;
   localparam int NODE_FIELD_W = 10;
   localparam int CMD_W        = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;
endpackage

// ===== design/lca_ram.sv =====
module lca_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== design/lca_nearest_alive_ancestor.sv =====
// channel | dir | tdata                          | tuser    | tlast
// req     | in  | node_a[9:0], node_b[19:10]     | cmd[1:0] | -
// rsp     | out | ancestor[9:0]                  | -        | -
// add: one ancestor-table read per level. delete: nothing for a dead node, else
// a find; a find walks up the representative chain a hop at a time, then
// compresses each node on the path. query: reads both depths, lifts the deeper
// node level by level, lifts both jointly per level and reads the parent if they
// differ, plus a find. all tables sit in single read port rams.
// synchronous reset, no clearing pass; a result waiting on rsp_tready lets the
// next word enter, and a query reaching its final step behind it holds there.
module lca_nearest_alive_ancestor #(
   parameter int MAX_NODES   = 1024,
   parameter int LIFT_LEVELS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // node_a[9:0], node_b[19:10], zero pad
   input  logic [1:0]  req_tuser,  // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // ancestor[9:0], zero pad
);
   import lca_pkg::*;

   `include "lca_nearest_alive_ancestor_defines.svh"

   localparam int NW  = $clog2(MAX_NODES);
   localparam int LW  = $clog2(LIFT_LEVELS);
   localparam int AAW = NW + LW;
   localparam int ANC_DEPTH = MAX_NODES * (1 << LW);
   localparam int HW  = NW + LIFT_LEVELS;
   localparam int XW  = NW + NODE_FIELD_W;
   localparam logic [LW-1:0] LVL_TOP = LW'(LIFT_LEVELS - 1);
   localparam logic [NW-1:0] ROOT    = NW'(1);

   typedef enum logic [4:0] {
      S_IDLE, S_ADD0, S_ADD1, S_ADD2,
      S_DEL0, S_DEL1, S_DEL2,
      S_QD0, S_QD1, S_QD2, S_QL, S_QLW, S_QCHK, S_QV, S_QU, S_QC, S_QP, S_QPW,
      S_FS, S_F1, S_F2, S_FEND
   } state_type;

   function automatic logic [NW-1:0] node_ix(input logic [NODE_FIELD_W-1:0] v);
      logic [XW-1:0] ext;
      ext = XW'(v);
      return (ext >= XW'(MAX_NODES)) ? '0 : ext[NW-1:0];
   endfunction

   state_type         state_ff;
   cmd_type           cmd_ff;
   logic [NW-1:0]     a_ff, b_ff, v_ff, u_ff, r_ff, x_ff, fstart_ff, tmp_ff, dv_ff;
   logic [LIFT_LEVELS-1:0] h_ff;
   logic [LW-1:0]     lvl_ff;
   logic [NW:0]       next_id_ff;
   logic              rsp_valid_ff;
   logic [NW-1:0]     rsp_node_ff;
   logic              anc_root_ff, dep_root_ff, rep_root_ff;

   // ram ports
   logic              anc_we, dep_we, rep_we;
   logic [AAW-1:0]    anc_waddr, anc_raddr;
   logic [NW-1:0]     anc_wdata, anc_raw, anc_rd;
   logic [NW-1:0]     dep_waddr, dep_raddr, dep_wdata, dep_raw, dep_rd;
   logic [NW-1:0]     rep_waddr, rep_raddr, rep_wdata, rep_raw, rep_rd;

   logic              req_accept;
   logic [NW-1:0]     t_node;
   logic [NW-1:0]     du;
   logic [NW-1:0]     hdiff;
   logic [HW-1:0]     h_ext;
   logic [LIFT_LEVELS-1:0] h_mask;
   logic [XW-1:0]     out_ext;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign t_node     = next_id_ff[NW-1:0];

   // root row reads as its reset value
   assign anc_rd = anc_root_ff ? ROOT : anc_raw;
   assign dep_rd = dep_root_ff ? '0 : dep_raw;
   assign rep_rd = rep_root_ff ? ROOT : rep_raw;

   assign du    = dep_rd;
   assign hdiff = (dv_ff < du) ? (du - dv_ff) : (dv_ff - du);
   assign h_ext = HW'(hdiff);
   // differences past the table reach take every level
   assign h_mask = ((h_ext >> LIFT_LEVELS) != '0) ? '1 : h_ext[LIFT_LEVELS-1:0];

   always_comb begin
      anc_we = 1'b0; anc_waddr = {t_node, lvl_ff}; anc_wdata = v_ff;
      anc_raddr = {v_ff, lvl_ff};
      dep_we = 1'b0; dep_waddr = t_node; dep_wdata = dep_rd + NW'(1);
      dep_raddr = a_ff;
      rep_we = 1'b0; rep_waddr = t_node; rep_wdata = t_node;
      rep_raddr = a_ff;
      unique case (state_ff)
         S_ADD0: begin
            anc_we = 1'b1; anc_waddr = {t_node, LW'(0)}; anc_wdata = a_ff;
         end
         S_ADD1: begin
            dep_we = 1'b1; rep_we = 1'b1;
            anc_raddr = {v_ff, lvl_ff - LW'(1)};
         end
         S_ADD2: begin
            anc_we = 1'b1; anc_wdata = anc_rd;
            anc_raddr = {anc_rd, lvl_ff};
         end
         S_DEL1:  anc_raddr = {a_ff, LW'(0)};
         S_QD1:   dep_raddr = b_ff;
         S_QU:    anc_raddr = {u_ff, lvl_ff};
         S_QP:    anc_raddr = {u_ff, LW'(0)};
         S_FS:    rep_raddr = x_ff;
         S_F1: begin
            rep_raddr = (rep_rd == r_ff) ? fstart_ff : rep_rd;
         end
         S_F2: begin
            rep_we = 1'b1; rep_waddr = x_ff; rep_wdata = r_ff;
            rep_raddr = rep_rd;
         end
         S_FEND: begin
            rep_we = (cmd_ff == CMD_DELETE);
            rep_waddr = a_ff; rep_wdata = r_ff;
         end
         default: begin
         end
      endcase
   end

   lca_ram #(.WIDTH(NW), .DEPTH(ANC_DEPTH)) u_anc (
      .clock, .we(anc_we), .waddr(anc_waddr), .wdata(anc_wdata),
      .raddr(anc_raddr), .rdata(anc_raw)
   );
   lca_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_dep (
      .clock, .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
      .raddr(dep_raddr), .rdata(dep_raw)
   );
   lca_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_rep (
      .clock, .we(rep_we), .waddr(rep_waddr), .wdata(rep_wdata),
      .raddr(rep_raddr), .rdata(rep_raw)
   );

   always_ff @(posedge clock) begin
      anc_root_ff <= (anc_raddr[AAW-1:LW] == ROOT);
      dep_root_ff <= (dep_raddr == ROOT);
      rep_root_ff <= (rep_raddr == ROOT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_id_ff   <= (NW+1)'(2);
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= CMD_NONE;
      end else begin
         // a query in its final step reloads the word itself
         if (rsp_valid_ff && rsp_tready &&
             !(state_ff == S_FEND && cmd_ff == CMD_QUERY)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  cmd_ff <= cmd_type'(req_tuser);
                  a_ff   <= node_ix(req_tdata[9:0]);
                  b_ff   <= node_ix(req_tdata[19:10]);
                  v_ff   <= node_ix(req_tdata[9:0]);
                  unique case (cmd_type'(req_tuser))
                     CMD_ADD: begin
                        if (next_id_ff < (NW+1)'(MAX_NODES)) begin
                           state_ff <= S_ADD0;
                        end
                     end
                     CMD_DELETE: state_ff <= S_DEL0;
                     CMD_QUERY:  state_ff <= S_QD0;
                     CMD_NONE:   state_ff <= S_IDLE;
                  endcase
               end
            end
            S_ADD0: begin
               lvl_ff   <= LW'(1);
               state_ff <= S_ADD1;
            end
            S_ADD1: state_ff <= S_ADD2;
            S_ADD2: begin
               v_ff <= anc_rd;
               if (lvl_ff == LVL_TOP) begin
                  next_id_ff <= next_id_ff + (NW+1)'(1);
                  state_ff   <= S_IDLE;
               end else begin
                  lvl_ff <= lvl_ff + LW'(1);
               end
            end
            S_DEL0: state_ff <= S_DEL1;
            S_DEL1: state_ff <= (rep_rd == a_ff) ? S_DEL2 : S_IDLE;
            S_DEL2: begin
               x_ff     <= anc_rd;
               state_ff <= S_FS;
            end
            S_QD0: state_ff <= S_QD1;
            S_QD1: begin
               dv_ff    <= dep_rd;
               state_ff <= S_QD2;
            end
            S_QD2: begin
               if (dv_ff < du) begin
                  v_ff <= b_ff; u_ff <= a_ff;
               end else begin
                  v_ff <= a_ff; u_ff <= b_ff;
               end
               h_ff     <= h_mask;
               lvl_ff   <= LVL_TOP;
               state_ff <= S_QL;
            end
            S_QL: begin
               if (h_ff[lvl_ff]) begin
                  state_ff <= S_QLW;
               end else if (lvl_ff == '0) begin
                  state_ff <= S_QCHK;
               end else begin
                  lvl_ff <= lvl_ff - LW'(1);
               end
            end
            S_QLW: begin
               v_ff <= anc_rd;
               if (lvl_ff == '0) begin
                  state_ff <= S_QCHK;
               end else begin
                  lvl_ff   <= lvl_ff - LW'(1);
                  state_ff <= S_QL;
               end
            end
            S_QCHK: begin
               if (v_ff == u_ff) begin
                  x_ff     <= v_ff;
                  state_ff <= S_FS;
               end else begin
                  lvl_ff   <= LVL_TOP;
                  state_ff <= S_QV;
               end
            end
            S_QV: state_ff <= S_QU;
            S_QU: begin
               tmp_ff   <= anc_rd;
               state_ff <= S_QC;
            end
            S_QC: begin
               if (tmp_ff != anc_rd) begin
                  v_ff <= tmp_ff;
                  u_ff <= anc_rd;
               end
               if (lvl_ff == '0) begin
                  state_ff <= S_QP;
               end else begin
                  lvl_ff   <= lvl_ff - LW'(1);
                  state_ff <= S_QV;
               end
            end
            S_QP:  state_ff <= S_QPW;
            S_QPW: begin
               x_ff     <= anc_rd;
               state_ff <= S_FS;
            end
            // find: walk to the representative, then compress the path
            S_FS: begin
               r_ff      <= x_ff;
               fstart_ff <= x_ff;
               state_ff  <= S_F1;
            end
            S_F1: begin
               if (rep_rd == r_ff) begin
                  x_ff     <= fstart_ff;
                  state_ff <= (fstart_ff == r_ff) ? S_FEND : S_F2;
               end else begin
                  r_ff <= rep_rd;
               end
            end
            S_F2: begin
               x_ff <= rep_rd;
               if (rep_rd == r_ff) begin
                  state_ff <= S_FEND;
               end
            end
            S_FEND: begin
               if (cmd_ff != CMD_QUERY) begin
                  state_ff <= S_IDLE;
               end else if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_node_ff  <= r_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign out_ext    = XW'(rsp_node_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, out_ext[NODE_FIELD_W-1:0]};

   `LCA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `LCA_ASSERT_IMP(a_next_id_cap, 1'b1, next_id_ff <= (NW+1)'(MAX_NODES))
   `LCA_ASSERT_NEXT(a_no_rsp_after_update, req_accept && req_tuser != CMD_QUERY, !$rose(rsp_tvalid))
   `LCA_ASSERT_IMP(a_rep_write_in_find, rep_we && state_ff == S_F2, rep_waddr != rep_raddr)
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import lca_pkg::*;

   localparam int NODES  = 1024;
   localparam int LEVELS = 10;

   typedef struct packed {
      cmd_type    cmd;
      logic [9:0] node_a;
      logic [9:0] node_b;
   } tree_op_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // node_a[9:0], node_b[19:10], zero pad
   logic [1:0]  req_tuser = CMD_ADD;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;   // ancestor[9:0], zero pad

   lca_nearest_alive_ancestor dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // tree mirror
   logic [9:0]  lift_tab [NODES][LEVELS];
   logic [9:0]  depth_of [NODES];
   logic [9:0]  rep_of [NODES];
   logic [10:0] mirror_next;
   logic [9:0]  ancestor_q [$];

   tree_op_type op_queue [$];
   tree_op_type cur_op;
   int          err_count = 0;
   int          n_add = 0, n_del = 0, n_query = 0, n_answers = 0;
   int          send_idle_pct = 0, rsp_stall_pct = 0;
   logic        rsp_hold = 1'b0;
   logic        hold_go = 1'b0;
   int          gen_next = 2;

   task automatic report(input string msg);
      err_count++;
      $display("mismatch: %s", msg);
   endtask

   function automatic logic [9:0] find_alive(input logic [9:0] v);
      logic [9:0] r, x, nx;
      int steps;
      r = v;
      steps = 0;
      while (rep_of[r] != r && steps < NODES) begin
         r = rep_of[r];
         steps++;
      end
      x = v;
      steps = 0;
      while (x != r && steps < NODES) begin
         nx = rep_of[x];
         rep_of[x] = r;
         x = nx;
         steps++;
      end
      return r;
   endfunction

   task automatic apply_op(input tree_op_type op);
      logic [9:0] v, u, s, hdiff;
      logic [10:0] t;
      case (op.cmd)
         CMD_ADD: begin
            n_add++;
            t = mirror_next;
            if (t < NODES) begin
               lift_tab[t][0] = op.node_a;
               depth_of[t] = depth_of[op.node_a] + 10'd1;
               rep_of[t] = t[9:0];
               for (int k = 1; k < LEVELS; k++)
                  lift_tab[t][k] = lift_tab[lift_tab[t][k-1]][k-1];
               mirror_next = t + 11'd1;
            end
         end
         CMD_DELETE: begin
            n_del++;
            if (rep_of[op.node_a] == op.node_a)
               rep_of[op.node_a] = find_alive(lift_tab[op.node_a][0]);
         end
         CMD_QUERY: begin
            n_query++;
            v = op.node_a;
            u = op.node_b;
            if (depth_of[v] < depth_of[u]) begin
               s = v; v = u; u = s;
            end
            hdiff = depth_of[v] - depth_of[u];
            for (int j = LEVELS - 1; j >= 0; j--) begin
               if ((11'd1 << j) <= hdiff) begin
                  hdiff -= 10'(1 << j);
                  v = lift_tab[v][j];
               end
            end
            if (v != u) begin
               for (int j = LEVELS - 1; j >= 0; j--) begin
                  if (lift_tab[v][j] != lift_tab[u][j]) begin
                     v = lift_tab[v][j];
                     u = lift_tab[u][j];
                  end
               end
               v = lift_tab[u][0];
            end
            ancestor_q.push_back(find_alive(v));
         end
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            apply_op(cur_op);
         if (!req_tvalid || req_tready) begin
            if (op_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_op     <= op_queue[0];
               req_tdata  <= {4'b0, op_queue[0].node_b, op_queue[0].node_a};
               req_tuser  <= op_queue[0].cmd;
               req_tvalid <= 1'b1;
               void'(op_queue.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            n_answers++;
            if (ancestor_q.size() == 0)
               report($sformatf("unexpected word ancestor=%0d", rsp_tdata[9:0]));
            else begin
               if (rsp_tdata[9:0] != ancestor_q[0])
                  report($sformatf("ancestor got %0d want %0d",
                                   rsp_tdata[9:0], ancestor_q[0]));
               void'(ancestor_q.pop_front());
            end
         end
         rsp_tready <= !rsp_hold && ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // long receiver hold-off
   initial begin
      wait (hold_go);
      @(negedge clock) rsp_hold = 1'b1;
      repeat (400) @(posedge clock);
      @(negedge clock) rsp_hold = 1'b0;
   end

   initial begin
      #10ms;
      $display("timeout");
      $display("Verification failed");
      $finish;
   end

   task automatic push_op(input cmd_type c, input int a, input int b);
      tree_op_type op;
      op.cmd = c;
      op.node_a = 10'(a);
      op.node_b = 10'(b);
      op_queue.push_back(op);
      if (c == CMD_ADD && gen_next < NODES)
         gen_next++;
   endtask

   // recent nodes half the time so the tree grows deep chains
   function automatic int pick_node();
      int span;
      span = gen_next - 2;
      if ($urandom_range(0, 1) == 0)
         return gen_next - 1 - $urandom_range(0, span < 4 ? span : 4);
      return $urandom_range(1, gen_next - 1);
   endfunction

   task automatic push_random(input int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 50)      push_op(CMD_ADD, pick_node(), $urandom_range(0, 1023));
         else if (r < 68) push_op(CMD_DELETE, pick_node(), $urandom_range(0, 1023));
         else if (r < 96) push_op(CMD_QUERY, pick_node(), pick_node());
         else             push_op(CMD_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023));
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (op_queue.size() != 0 || req_tvalid || ancestor_q.size() != 0);
   endtask

   initial begin
      for (int i = 0; i < NODES; i++) begin
         for (int j = 0; j < LEVELS; j++)
            lift_tab[i][j] = (i == 1) ? 10'd1 : 10'd0;
         depth_of[i] = '0;
         rep_of[i] = (i == 1) ? 10'd1 : 10'd0;
      end
      mirror_next = 11'd2;
      repeat (9) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // directed: root cases, small tree, deletes, repeated delete, unused code
      push_op(CMD_QUERY, 1, 1);
      push_op(CMD_DELETE, 1, 0);
      push_op(CMD_ADD, 1, 1023);
      push_op(CMD_ADD, 2, 0);
      push_op(CMD_ADD, 3, 0);
      push_op(CMD_ADD, 2, 0);
      push_op(CMD_QUERY, 4, 5);
      push_op(CMD_QUERY, 5, 4);
      push_op(CMD_QUERY, 4, 4);
      push_op(CMD_QUERY, 1, 4);
      push_op(CMD_DELETE, 2, 0);
      push_op(CMD_QUERY, 4, 5);
      push_op(CMD_DELETE, 2, 0);
      push_op(CMD_DELETE, 3, 0);
      push_op(CMD_QUERY, 4, 4);
      push_op(CMD_QUERY, 3, 4);
      push_op(CMD_NONE, 1023, 1023);
      push_op(CMD_QUERY, 5, 1);
      wait_drained();

      // no idling
      push_random(400);
      wait_drained();
      // sender pauses above until drained, then receiver blocked while sender streams
      @(negedge clock) hold_go = 1'b1;
      push_random(60);
      wait_drained();
      @(negedge clock) begin
         send_idle_pct = 63;
         rsp_stall_pct = 0;
      end
      push_random(380);
      wait_drained();
      @(negedge clock) begin
         send_idle_pct = 0;
         rsp_stall_pct = 63;
      end
      push_random(380);
      wait_drained();
      @(negedge clock) begin
         send_idle_pct = 15;
         rsp_stall_pct = 15;
      end
      push_random(300);
      // fill to capacity, then adds that must be ignored, then queries over the full id range
      while (gen_next < NODES)
         push_op(CMD_ADD, pick_node(), 0);
      for (int i = 0; i < 4; i++)
         push_op(CMD_ADD, $urandom_range(1, 1023), 1023);
      push_op(CMD_QUERY, 1023, 1022);
      push_op(CMD_QUERY, 1023, 1);
      push_op(CMD_DELETE, 1023, 0);
      push_op(CMD_QUERY, 1023, 512);
      push_random(150);
      wait_drained();
      repeat (3000) @(posedge clock);

      $display("covered %0d adds, %0d deletes, %0d queries; %0d answers checked",
               n_add, n_del, n_query, n_answers);
      $display("tree grew to %0d nodes, with ignored adds at capacity and idle phases",
               mirror_next - 1);
      if (err_count == 0 && ancestor_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+design
design/lca_pkg.sv
design/lca_ram.sv
design/lca_nearest_alive_ancestor.sv
tb/sv/testbench.sv
